@@ hdl/ple_pkg.sv @@
// Shared types and constants for the positional list engine.
`timescale 1ns / 1ps
package ple_pkg;

    // Default number of list cells
    localparam int unsigned DEF_CAPACITY = 16;

    // Fixed field widths of the transfer payloads
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 5;
    localparam int unsigned COUNT_W = 5;

    // Operation codes carried in the kind field
    typedef enum logic [1:0] {
        KIND_INSERT = 2'd0,
        KIND_DELETE = 2'd1,
        KIND_SORT   = 2'd2,
        KIND_DUMP   = 2'd3
    } t_kind;

    // Per-cycle command broadcast to every cell
    typedef enum logic [2:0] {
        CMD_HOLD   = 3'd0,
        CMD_INSERT = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_SORT   = 3'd3,
        CMD_ROTATE = 3'd4
    } t_cmd;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_SORT = 2'd1,
        ST_DUMP = 2'd2
    } t_state;

    // Command transfer payload
    typedef struct packed {
        t_kind                      kind;
        logic [POS_W-1:0]           position;
        logic signed [VALUE_W-1:0]  value_in;
    } t_cmd_item;

    // Result transfer payload
    typedef struct packed {
        logic                       ok;
        logic signed [VALUE_W-1:0]  value_out;
        logic                       entry_valid;
        logic [COUNT_W-1:0]         count;
        logic                       last;
    } t_result_item;

    // Control group from the sequencer to the cell row
    typedef struct packed {
        t_cmd                       cmd;
        logic [POS_W-1:0]           pos0;
        logic                       phase;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_ctrl;

endpackage

@@ hdl/positional_list_engine.sv @@
// Top level of the positional list engine: sequencer and row of cells.
//
//  Channel   Ports                        Transfer
//  command   start, i_cmd, busy (out)     rising edge with start high and busy low
//  result    o_valid, o_result            one cycle with o_valid high, always taken
//
// Insert and delete shift the cell row; the result appears in the next
// cycle and busy stays low. Sort runs CAPACITY odd-even transposition
// rounds over the cell row, one round a cycle, then gives one result.
// Dump rotates the row once per entry and gives one result per cycle; an
// empty list gives a single result. Reset empties the list; cell contents
// are not cleared. Results cannot be stalled.
`timescale 1ns / 1ps
module positional_list_engine
    import ple_pkg::*;
#(
    parameter int unsigned CAPACITY = DEF_CAPACITY
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         start,
    input  t_cmd_item    i_cmd,
    output logic         busy,
    output logic         o_valid,
    output t_result_item o_result
);

    localparam int unsigned CW  = $clog2(CAPACITY + 1);
    localparam int unsigned RW  = $clog2(CAPACITY);

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [RW-1:0]             r_cnt, n_cnt;
    logic                      r_valid, n_valid;
    t_result_item              r_res, n_res;
    t_cell_ctrl                w_ctrl;
    logic signed [VALUE_W-1:0] w_cell [CAPACITY];
    logic signed [VALUE_W-1:0] w_removed;
    logic                      w_ins_ok;
    logic                      w_del_ok;

    // Build the row of cells
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VALUE_W-1:0] w_left;
        logic signed [VALUE_W-1:0] w_right;
        if (g == 0) begin : g_first
            assign w_left = i_cmd.value_in;
        end else begin : g_mid_l
            assign w_left = w_cell[g-1];
        end
        if (g == CAPACITY - 1) begin : g_end
            assign w_right = w_cell[g];
        end else begin : g_mid_r
            assign w_right = w_cell[g+1];
        end
        ple_cell #(
            .IDX (g),
            .CW  (CW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (w_ctrl),
            .i_count (r_count),
            .i_left  (w_left),
            .i_right (w_right),
            .i_head  (w_cell[0]),
            .o_value (w_cell[g])
        );
    end

    // Select the entry a delete removes
    always_comb begin
        w_removed = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (k + 1 == int'(i_cmd.position)) begin
                w_removed = w_cell[k];
            end
        end
    end

    // Range checks for insert and delete
    assign w_ins_ok = (i_cmd.position != '0)
                   && (int'(i_cmd.position) <= int'(r_count) + 1)
                   && (int'(r_count) < CAPACITY);
    assign w_del_ok = (i_cmd.position != '0)
                   && (int'(i_cmd.position) <= int'(r_count));

    // Next state, cell commands and results
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_cnt        = r_cnt;
        n_valid      = 1'b0;
        n_res        = r_res;
        w_ctrl.cmd   = CMD_HOLD;
        w_ctrl.pos0  = i_cmd.position - POS_W'(1);
        w_ctrl.phase = r_cnt[0];
        w_ctrl.value = i_cmd.value_in;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_cmd.kind)
                        KIND_INSERT: begin
                            if (w_ins_ok) begin
                                w_ctrl.cmd = CMD_INSERT;
                                n_count    = r_count + CW'(1);
                            end
                            n_valid           = 1'b1;
                            n_res.ok          = w_ins_ok;
                            n_res.value_out   = '0;
                            n_res.entry_valid = 1'b0;
                            n_res.count       = COUNT_W'(n_count);
                            n_res.last        = 1'b1;
                        end
                        KIND_DELETE: begin
                            if (w_del_ok) begin
                                w_ctrl.cmd = CMD_DELETE;
                                n_count    = r_count - CW'(1);
                            end
                            n_valid           = 1'b1;
                            n_res.ok          = w_del_ok;
                            n_res.value_out   = w_del_ok ? w_removed : '0;
                            n_res.entry_valid = w_del_ok;
                            n_res.count       = COUNT_W'(n_count);
                            n_res.last        = 1'b1;
                        end
                        KIND_SORT: begin
                            n_state = ST_SORT;
                            n_cnt   = '0;
                        end
                        KIND_DUMP: begin
                            if (r_count == '0) begin
                                n_valid           = 1'b1;
                                n_res.ok          = 1'b1;
                                n_res.value_out   = '0;
                                n_res.entry_valid = 1'b0;
                                n_res.count       = '0;
                                n_res.last        = 1'b1;
                            end else begin
                                n_state = ST_DUMP;
                                n_cnt   = '0;
                            end
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SORT: begin
                // One transposition round per cycle
                w_ctrl.cmd = CMD_SORT;
                if (int'(r_cnt) == CAPACITY - 1) begin
                    n_state           = ST_IDLE;
                    n_valid           = 1'b1;
                    n_res.ok          = 1'b1;
                    n_res.value_out   = '0;
                    n_res.entry_valid = 1'b0;
                    n_res.count       = COUNT_W'(r_count);
                    n_res.last        = 1'b1;
                end else begin
                    n_cnt = r_cnt + RW'(1);
                end
            end
            ST_DUMP: begin
                // Emit the head cell and rotate the list by one
                w_ctrl.cmd        = CMD_ROTATE;
                n_valid           = 1'b1;
                n_res.ok          = 1'b1;
                n_res.value_out   = w_cell[0];
                n_res.entry_valid = 1'b1;
                n_res.count       = COUNT_W'(r_count);
                n_res.last        = (int'(r_cnt) + 1 == int'(r_count));
                if (int'(r_cnt) + 1 == int'(r_count)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + RW'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
    end

    // Result payload register
    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign busy     = (r_state != ST_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_res;

endmodule

@@ hdl/ple_cell.sv @@
// One list cell: holds a value and trades it with its neighbors.
`timescale 1ns / 1ps
module ple_cell
    import ple_pkg::*;
#(
    parameter int unsigned IDX = 0,
    parameter int unsigned CW  = 5
) (
    input  logic                      i_clk,
    input  t_cell_ctrl                i_ctrl,
    input  logic [CW-1:0]             i_count,
    input  logic signed [VALUE_W-1:0] i_left,
    input  logic signed [VALUE_W-1:0] i_right,
    input  logic signed [VALUE_W-1:0] i_head,
    output logic signed [VALUE_W-1:0] o_value
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;
    logic                      w_lower;

    // Even phase pairs cells (0,1),(2,3)...; odd phase pairs (1,2),(3,4)...
    assign w_lower = ((IDX % 2) == 0) ? !i_ctrl.phase : i_ctrl.phase;

    // Pick the next cell value from the broadcast command
    always_comb begin
        n_value = r_value;
        case (i_ctrl.cmd)
            CMD_INSERT: begin
                if (IDX == int'(i_ctrl.pos0)) begin
                    n_value = i_ctrl.value;
                end else if (IDX > int'(i_ctrl.pos0)) begin
                    n_value = i_left;
                end
            end
            CMD_DELETE: begin
                if (IDX >= int'(i_ctrl.pos0)) begin
                    n_value = i_right;
                end
            end
            CMD_SORT: begin
                if (w_lower) begin
                    if ((IDX + 1 < int'(i_count)) && (i_right < r_value)) begin
                        n_value = i_right;
                    end
                end else begin
                    if ((IDX >= 1) && (IDX < int'(i_count)) && (i_left > r_value)) begin
                        n_value = i_left;
                    end
                end
            end
            CMD_ROTATE: begin
                if (IDX + 1 < int'(i_count)) begin
                    n_value = i_right;
                end else if (IDX + 1 == int'(i_count)) begin
                    n_value = i_head;
                end
            end
            default: begin
                n_value = r_value;
            end
        endcase
    end

    // Hold the cell value
    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

@@ verif/tb_positional_list_engine.sv @@
// Self-checking testbench for the positional list engine.
`timescale 1ns / 1ps
module tb_positional_list_engine;
    import ple_pkg::*;

    localparam int unsigned CAP        = DEF_CAPACITY;
    localparam int unsigned IDLE_LIMIT = 5000;
    localparam int unsigned ITEM_GOAL  = 480;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    logic         i_clk;
    logic         i_rst_n;
    logic         start;
    t_cmd_item    i_cmd;
    logic         busy;
    logic         o_valid;
    t_result_item o_result;

    positional_list_engine #(
        .CAPACITY (CAP)
    ) i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    // Shadow copy of the list and the results it predicts
    logic signed [VALUE_W-1:0] shadow_cells [CAP];
    int unsigned               shadow_len;
    t_result_item              expected_results [$];

    int unsigned error_count;
    int unsigned items_sent;
    int unsigned results_seen;
    int unsigned kind_sent [4];
    int unsigned full_rejects;
    int unsigned peak_len;
    int unsigned idle_cycles;
    bit          no_gaps;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Fold one accepted command into the shadow list and queue its results
    function automatic void apply_list_op(input t_cmd_item cmd);
        t_result_item             res;
        int unsigned              p;
        logic signed [VALUE_W-1:0] tmp;
        p   = 32'(cmd.position);
        res = '0;
        res.last = 1'b1;
        case (cmd.kind)
            KIND_INSERT: begin
                if (p >= 1 && p <= shadow_len + 1 && shadow_len < CAP) begin
                    for (int i = shadow_len; i >= p; i--)
                        shadow_cells[i] = shadow_cells[i-1];
                    shadow_cells[p-1] = cmd.value_in;
                    shadow_len++;
                    res.ok = 1'b1;
                end else if (shadow_len == CAP) begin
                    full_rejects++;
                end
                res.count = COUNT_W'(shadow_len);
                expected_results.push_back(res);
            end
            KIND_DELETE: begin
                if (p >= 1 && p <= shadow_len) begin
                    res.ok          = 1'b1;
                    res.entry_valid = 1'b1;
                    res.value_out   = shadow_cells[p-1];
                    for (int i = p - 1; i + 1 < shadow_len; i++)
                        shadow_cells[i] = shadow_cells[i+1];
                    shadow_len--;
                end
                res.count = COUNT_W'(shadow_len);
                expected_results.push_back(res);
            end
            KIND_SORT: begin
                for (int i = 0; i + 1 < shadow_len; i++)
                    for (int j = i + 1; j < shadow_len; j++)
                        if (shadow_cells[i] > shadow_cells[j]) begin
                            tmp             = shadow_cells[i];
                            shadow_cells[i] = shadow_cells[j];
                            shadow_cells[j] = tmp;
                        end
                res.ok    = 1'b1;
                res.count = COUNT_W'(shadow_len);
                expected_results.push_back(res);
            end
            default: begin
                res.ok    = 1'b1;
                res.count = COUNT_W'(shadow_len);
                if (shadow_len == 0) begin
                    expected_results.push_back(res);
                end else begin
                    for (int i = 0; i < shadow_len; i++) begin
                        res.value_out   = shadow_cells[i];
                        res.entry_valid = 1'b1;
                        res.last        = (i + 1 == shadow_len);
                        expected_results.push_back(res);
                    end
                end
            end
        endcase
        if (shadow_len > peak_len)
            peak_len = shadow_len;
    endfunction

    // Values: mostly random, some from a narrow band for duplicates, some extremes
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 25)
            return $signed($urandom_range(0, 6)) - 3;
        if (roll < 30)
            return VAL_MAX;
        if (roll < 35)
            return VAL_MIN;
        return $urandom;
    endfunction

    // Sender gap: mostly none or short, now and then long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        if (no_gaps)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 96)
            return $urandom_range(4, 9);
        return $urandom_range(10, 40);
    endfunction

    task automatic report_mismatch(input string what, input longint exp_v,
                                   input longint got_v);
        error_count++;
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    endtask

    // Drive one command, hold it until the transfer, then idle for a gap
    task automatic send_item(input t_kind kind, input int unsigned pos,
                             input logic signed [VALUE_W-1:0] val);
        t_cmd_item   cmd;
        int unsigned gap;
        cmd.kind     = kind;
        cmd.position = pos[POS_W-1:0];
        cmd.value_in = val;
        start <= 1'b1;
        i_cmd <= cmd;
        @(posedge i_clk);
        while (busy)
            @(posedge i_clk);
        apply_list_op(cmd);
        items_sent++;
        kind_sent[kind]++;
        gap = pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Hold off the sender until every queued result has come back
    task automatic wait_drained();
        start <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Check every result transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_result_item exp_r;
        if (i_rst_n && o_valid) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                error_count++;
                $display("[%0t] MISMATCH unexpected result, value %0d", $time,
                         o_result.value_out);
            end else begin
                exp_r = expected_results.pop_front();
                if (o_result.ok !== exp_r.ok)
                    report_mismatch("ok", exp_r.ok, o_result.ok);
                if (o_result.value_out !== exp_r.value_out)
                    report_mismatch("value_out", exp_r.value_out, o_result.value_out);
                if (o_result.entry_valid !== exp_r.entry_valid)
                    report_mismatch("entry_valid", exp_r.entry_valid, o_result.entry_valid);
                if (o_result.count !== exp_r.count)
                    report_mismatch("count", exp_r.count, o_result.count);
                if (o_result.last !== exp_r.last)
                    report_mismatch("last", exp_r.last, o_result.last);
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[%0t] watchdog expired with %0d results outstanding", $time,
                     expected_results.size());
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Operations on an empty list, all of which leave it empty
    task automatic test_empty_list();
        send_item(KIND_DUMP, 0, 0);
        send_item(KIND_DELETE, 1, 0);
        send_item(KIND_SORT, 0, 0);
        send_item(KIND_INSERT, 0, 32'sd5);
        send_item(KIND_INSERT, 2, 32'sd5);
    endtask

    // Extreme values and positions, first and last entry handling
    task automatic test_edge_values();
        send_item(KIND_INSERT, 1, VAL_MAX);
        send_item(KIND_INSERT, 1, VAL_MIN);
        send_item(KIND_INSERT, 3, 0);
        send_item(KIND_INSERT, 2, -1);
        send_item(KIND_INSERT, 6, 32'sd7);
        send_item(KIND_INSERT, 31, 32'sd7);
        send_item(KIND_DELETE, 0, 0);
        send_item(KIND_DELETE, 5, 0);
        send_item(KIND_DUMP, 31, VAL_MAX);
        send_item(KIND_SORT, 17, VAL_MIN);
        send_item(KIND_DUMP, 0, 0);
        send_item(KIND_DELETE, 4, 0);
        send_item(KIND_DELETE, 1, 0);
        send_item(KIND_DELETE, 2, 0);
        send_item(KIND_DUMP, 0, 0);
        send_item(KIND_DELETE, 1, 0);
        send_item(KIND_DUMP, 0, 0);
    endtask

    // Fill to capacity, hit the full bound, sort, then drain
    task automatic test_full_list();
        while (shadow_len < CAP)
            send_item(KIND_INSERT, $urandom_range(1, shadow_len + 1), pick_value());
        send_item(KIND_INSERT, 1, 32'sd1);
        send_item(KIND_INSERT, CAP + 1, 32'sd1);
        send_item(KIND_INSERT, 31, 32'sd1);
        send_item(KIND_DELETE, CAP + 1, 0);
        send_item(KIND_DELETE, CAP, 0);
        send_item(KIND_INSERT, CAP, VAL_MIN);
        send_item(KIND_DUMP, 0, 0);
        send_item(KIND_SORT, 0, 0);
        send_item(KIND_DUMP, 0, 0);
        wait_drained();
        while (shadow_len > 0)
            send_item(KIND_DELETE, $urandom_range(1, shadow_len), pick_value());
    endtask

    // Random operations in phases that grow, shrink or churn the list
    task automatic test_random_ops();
        int unsigned phase;
        int unsigned roll;
        int unsigned ins_pct;
        int unsigned del_pct;
        int unsigned pos;
        t_kind       kind;
        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            case (phase % 3)
                0:       begin ins_pct = 65; del_pct = 15; end
                1:       begin ins_pct = 15; del_pct = 65; end
                default: begin ins_pct = 40; del_pct = 30; end
            endcase
            no_gaps = ($urandom_range(0, 3) == 0);
            repeat (40) begin
                roll = $urandom_range(0, 99);
                if (roll < ins_pct)
                    kind = KIND_INSERT;
                else if (roll < ins_pct + del_pct)
                    kind = KIND_DELETE;
                else if (roll < ins_pct + del_pct + 10)
                    kind = KIND_SORT;
                else
                    kind = KIND_DUMP;
                // Mostly in-range positions, sometimes anything the field holds
                if ($urandom_range(0, 99) < 20)
                    pos = $urandom_range(0, 31);
                else if (kind == KIND_INSERT)
                    pos = $urandom_range(1, shadow_len + 1);
                else if (kind == KIND_DELETE && shadow_len > 0)
                    pos = $urandom_range(1, shadow_len);
                else
                    pos = $urandom_range(0, 31);
                send_item(kind, pos, pick_value());
            end
            no_gaps = 1'b0;
            if (phase % 4 == 3)
                wait_drained();
            phase++;
        end
    endtask

    // Stimulus sequence
    initial begin
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_cmd        = '0;
        error_count  = 0;
        items_sent   = 0;
        results_seen = 0;
        full_rejects = 0;
        peak_len     = 0;
        idle_cycles  = 0;
        no_gaps      = 1'b0;
        shadow_len   = 0;
        foreach (kind_sent[k])
            kind_sent[k] = 0;
        foreach (shadow_cells[k])
            shadow_cells[k] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_edge_values();
        test_full_list();
        test_random_ops();

        // Let the last results arrive, then watch for stray ones
        wait_drained();
        repeat (CAP + 8) @(posedge i_clk);

        $display("Sent %0d commands (insert %0d, delete %0d, sort %0d, dump %0d),",
                 items_sent, kind_sent[KIND_INSERT], kind_sent[KIND_DELETE],
                 kind_sent[KIND_SORT], kind_sent[KIND_DUMP]);
        $display("checked %0d results; peak fill %0d, %0d inserts refused when full.",
                 results_seen, peak_len, full_rejects);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results missing", error_count,
                     expected_results.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
